[rtl/dseq_pkg.sv]
// Package for the deployment sequencer: state and fault codes, register map,
// stream payload widths. Used by deployment_sequencer_unit; depends on nothing.
`default_nettype none

package dseq_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 4;
    localparam int ADDR_W     = 5;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 24;

    typedef enum logic [3:0] {
        ST_INHIBITED = 4'd0,
        ST_WAITING   = 4'd1,
        ST_ANT_PEND  = 4'd2,
        ST_ANT_ACT   = 4'd3,
        ST_ANT_VER   = 4'd4,
        ST_SOL_PEND  = 4'd5,
        ST_SOL_ACT   = 4'd6,
        ST_SOL_VER   = 4'd7,
        ST_COMPLETE  = 4'd8,
        ST_FAILED    = 4'd9
    } state_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_ANTENNA = 2'd1,
        FAULT_SOLAR   = 2'd2,
        FAULT_INVALID = 2'd3
    } fault_t;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_RETRY    = 1'b1;
    localparam logic ELEM_ANTENNA = 1'b0;
    localparam logic ELEM_SOLAR   = 1'b1;

    localparam logic [2:0] REG_WAIT_TIME     = 3'd0;
    localparam logic [2:0] REG_ANTENNA_BURN  = 3'd1;
    localparam logic [2:0] REG_SOLAR_BURN    = 3'd2;
    localparam logic [2:0] REG_VERIFY_TIME   = 3'd3;
    localparam logic [2:0] REG_RETRY_DELAY   = 3'd4;
    localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd5;
    localparam logic [2:0] REG_DEPLOY_ENABLE = 3'd6;

    localparam logic [TIME_W-1:0]  RST_WAIT_TIME    = 32'd1800000;
    localparam logic [TIME_W-1:0]  RST_ANTENNA_BURN = 32'd10000;
    localparam logic [TIME_W-1:0]  RST_SOLAR_BURN   = 32'd10000;
    localparam logic [TIME_W-1:0]  RST_VERIFY_TIME  = 32'd5000;
    localparam logic [TIME_W-1:0]  RST_RETRY_DELAY  = 32'd5000;
    localparam logic [COUNT_W-1:0] RST_MAX_ATTEMPTS = 4'd3;

endpackage

`default_nettype wire

[rtl/deployment_sequencer_unit.sv]
// Deployment sequencer top level: stream input and output, APB register port,
// sequencing state machine. Depends on dseq_pkg.
//
// Usage: each input transaction is a timer tick (s_tuser = 0) or a forced
// retry command (s_tuser = 1); s_tdata carries the time in ms and the switch
// and element fields. Every input transaction yields exactly one status
// transaction on the m_ channel, showing the state after the item is applied.
// The burn-wire drive is reported in the status as burn_enable.
// The item is captured in an input register; combinational logic (a 32-bit
// time subtraction, a few compares and the state update) then loads the
// state registers and the result register, which drives m_tvalid. One item
// is accepted every cycle while the receiver keeps m_tready high.
// When the receiver holds m_tready low, the result register keeps its
// transaction and the input register keeps the next item; s_tready drops only
// when both are full, so no transaction is lost or repeated.
// Reset (aresetn low, synchronous) empties both registers, puts the sequencer
// in the inhibited state with cleared counts and flags, and loads the
// configuration registers with their default values. The user must write the
// configuration via the APB port only while idle; the block does not enforce it.
`default_nettype none

module deployment_sequencer_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // now_ms[31:0], separation_switch[32], deployed_sense[33], retry_element[34]
    input  wire logic [dseq_pkg::S_DATA_W-1:0]    s_tdata,
    // cmd[0]
    input  wire logic                             s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // seq_state[3:0], burn_enable[4], separated[5], ant_confirmed[6],
    // antenna_tries[10:7], sol_confirmed[11], solar_tries[15:12],
    // fault_event[17:16], save_request[18]
    output logic [dseq_pkg::M_DATA_W-1:0]         m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [dseq_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [dseq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [dseq_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    // Configuration registers.
    logic [dseq_pkg::TIME_W-1:0]  wait_time_reg;
    logic [dseq_pkg::TIME_W-1:0]  antenna_burn_reg;
    logic [dseq_pkg::TIME_W-1:0]  solar_burn_reg;
    logic [dseq_pkg::TIME_W-1:0]  verify_time_reg;
    logic [dseq_pkg::TIME_W-1:0]  retry_delay_reg;
    logic [dseq_pkg::COUNT_W-1:0] max_attempts_reg;
    logic                         deploy_enable_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_time_reg     <= dseq_pkg::RST_WAIT_TIME;
            antenna_burn_reg  <= dseq_pkg::RST_ANTENNA_BURN;
            solar_burn_reg    <= dseq_pkg::RST_SOLAR_BURN;
            verify_time_reg   <= dseq_pkg::RST_VERIFY_TIME;
            retry_delay_reg   <= dseq_pkg::RST_RETRY_DELAY;
            max_attempts_reg  <= dseq_pkg::RST_MAX_ATTEMPTS;
            deploy_enable_reg <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_index)
                dseq_pkg::REG_WAIT_TIME:     wait_time_reg     <= pwdata;
                dseq_pkg::REG_ANTENNA_BURN:  antenna_burn_reg  <= pwdata;
                dseq_pkg::REG_SOLAR_BURN:    solar_burn_reg    <= pwdata;
                dseq_pkg::REG_VERIFY_TIME:   verify_time_reg   <= pwdata;
                dseq_pkg::REG_RETRY_DELAY:   retry_delay_reg   <= pwdata;
                dseq_pkg::REG_MAX_ATTEMPTS:  max_attempts_reg  <= pwdata[3:0];
                dseq_pkg::REG_DEPLOY_ENABLE: deploy_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            dseq_pkg::REG_WAIT_TIME:     prdata = wait_time_reg;
            dseq_pkg::REG_ANTENNA_BURN:  prdata = antenna_burn_reg;
            dseq_pkg::REG_SOLAR_BURN:    prdata = solar_burn_reg;
            dseq_pkg::REG_VERIFY_TIME:   prdata = verify_time_reg;
            dseq_pkg::REG_RETRY_DELAY:   prdata = retry_delay_reg;
            dseq_pkg::REG_MAX_ATTEMPTS:  prdata = {28'd0, max_attempts_reg};
            dseq_pkg::REG_DEPLOY_ENABLE: prdata = {31'd0, deploy_enable_reg};
            default:                     prdata = '0;
        endcase
    end

    // Input register and result register handshake.
    logic                        in_valid_reg;
    logic                        in_cmd_reg;
    logic [dseq_pkg::TIME_W-1:0] in_now_reg;
    logic                        in_sep_reg;
    logic                        in_sense_reg;
    logic                        in_elem_reg;
    logic                        m_valid_reg;
    logic [dseq_pkg::M_DATA_W-1:0] m_data_reg;
    logic                        out_free;
    logic                        step;
    logic                        s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg   <= s_tuser;
            in_now_reg   <= s_tdata[31:0];
            in_sep_reg   <= s_tdata[32];
            in_sense_reg <= s_tdata[33];
            in_elem_reg  <= s_tdata[34];
        end
    end

    // Sequencer state.
    dseq_pkg::state_t             state_reg, state_next;
    logic [dseq_pkg::TIME_W-1:0]  entry_time_reg, entry_time_next;
    logic [dseq_pkg::COUNT_W-1:0] antenna_count_reg, antenna_count_next;
    logic [dseq_pkg::COUNT_W-1:0] solar_count_reg, solar_count_next;
    logic                         antenna_done_reg, antenna_done_next;
    logic                         solar_done_reg, solar_done_next;
    logic                         sep_seen_reg, sep_seen_next;
    logic                         burn_on_reg, burn_on_next;
    dseq_pkg::fault_t             fault_next;
    logic                         save_next;
    logic [dseq_pkg::TIME_W-1:0]  state_age;
    logic                         verify_elapsed;

    assign state_age      = in_now_reg - entry_time_reg;
    assign verify_elapsed = (state_age >= verify_time_reg)
                            && (state_age >= retry_delay_reg);

    always_comb begin
        state_next         = state_reg;
        entry_time_next    = entry_time_reg;
        antenna_count_next = antenna_count_reg;
        solar_count_next   = solar_count_reg;
        antenna_done_next  = antenna_done_reg;
        solar_done_next    = solar_done_reg;
        sep_seen_next      = sep_seen_reg;
        burn_on_next       = burn_on_reg;
        fault_next         = dseq_pkg::FAULT_NONE;
        save_next          = 1'b0;

        if (in_cmd_reg == dseq_pkg::CMD_RETRY) begin
            entry_time_next = in_now_reg;
            if (in_elem_reg == dseq_pkg::ELEM_ANTENNA) begin
                antenna_count_next = '0;
                antenna_done_next  = 1'b0;
                state_next         = dseq_pkg::ST_ANT_PEND;
            end else begin
                solar_count_next = '0;
                solar_done_next  = 1'b0;
                state_next       = dseq_pkg::ST_SOL_PEND;
            end
        end else begin
            case (state_reg)
                dseq_pkg::ST_INHIBITED: begin
                    if (in_sep_reg) begin
                        sep_seen_next   = 1'b1;
                        state_next      = dseq_pkg::ST_WAITING;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_WAITING: begin
                    if ((state_age >= wait_time_reg) && deploy_enable_reg) begin
                        state_next      = dseq_pkg::ST_ANT_PEND;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_ANT_PEND: begin
                    entry_time_next = in_now_reg;
                    if (in_sense_reg) begin
                        antenna_done_next = 1'b1;
                        state_next        = dseq_pkg::ST_SOL_PEND;
                    end else if (antenna_count_reg < max_attempts_reg) begin
                        burn_on_next       = 1'b1;
                        antenna_count_next = antenna_count_reg + 4'd1;
                        state_next         = dseq_pkg::ST_ANT_ACT;
                    end else begin
                        state_next = dseq_pkg::ST_FAILED;
                        fault_next = dseq_pkg::FAULT_ANTENNA;
                    end
                end
                dseq_pkg::ST_ANT_ACT: begin
                    if (state_age >= antenna_burn_reg) begin
                        burn_on_next    = 1'b0;
                        state_next      = dseq_pkg::ST_ANT_VER;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_ANT_VER: begin
                    if (in_sense_reg) begin
                        antenna_done_next = 1'b1;
                        state_next        = dseq_pkg::ST_SOL_PEND;
                        entry_time_next   = in_now_reg;
                    end else if (verify_elapsed) begin
                        state_next      = dseq_pkg::ST_ANT_PEND;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_SOL_PEND: begin
                    entry_time_next = in_now_reg;
                    if (in_sense_reg) begin
                        solar_done_next = 1'b1;
                        state_next      = dseq_pkg::ST_COMPLETE;
                    end else if (solar_count_reg < max_attempts_reg) begin
                        burn_on_next     = 1'b1;
                        solar_count_next = solar_count_reg + 4'd1;
                        state_next       = dseq_pkg::ST_SOL_ACT;
                    end else begin
                        state_next = dseq_pkg::ST_FAILED;
                        fault_next = dseq_pkg::FAULT_SOLAR;
                    end
                end
                dseq_pkg::ST_SOL_ACT: begin
                    if (state_age >= solar_burn_reg) begin
                        burn_on_next    = 1'b0;
                        state_next      = dseq_pkg::ST_SOL_VER;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_SOL_VER: begin
                    if (in_sense_reg) begin
                        solar_done_next = 1'b1;
                        state_next      = dseq_pkg::ST_COMPLETE;
                        entry_time_next = in_now_reg;
                    end else if (verify_elapsed) begin
                        state_next      = dseq_pkg::ST_SOL_PEND;
                        entry_time_next = in_now_reg;
                    end
                end
                dseq_pkg::ST_COMPLETE: begin
                    save_next = 1'b1;
                end
                dseq_pkg::ST_FAILED: ;
                default: begin
                    state_next      = dseq_pkg::ST_INHIBITED;
                    entry_time_next = in_now_reg;
                    fault_next      = dseq_pkg::FAULT_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= dseq_pkg::ST_INHIBITED;
            entry_time_reg    <= '0;
            antenna_count_reg <= '0;
            solar_count_reg   <= '0;
            antenna_done_reg  <= 1'b0;
            solar_done_reg    <= 1'b0;
            sep_seen_reg      <= 1'b0;
            burn_on_reg       <= 1'b0;
        end else if (step) begin
            state_reg         <= state_next;
            entry_time_reg    <= entry_time_next;
            antenna_count_reg <= antenna_count_next;
            solar_count_reg   <= solar_count_next;
            antenna_done_reg  <= antenna_done_next;
            solar_done_reg    <= solar_done_next;
            sep_seen_reg      <= sep_seen_next;
            burn_on_reg       <= burn_on_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= {5'd0, save_next, fault_next, solar_count_next,
                           solar_done_next, antenna_count_next, antenna_done_next,
                           sep_seen_next, burn_on_next, state_next};
        end
    end

    // A failure fault is only ever reported together with the failed state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg[17:16] == dseq_pkg::FAULT_ANTENNA
                        || m_data_reg[17:16] == dseq_pkg::FAULT_SOLAR)
        |-> m_data_reg[3:0] == dseq_pkg::ST_FAILED)
        else $error("failure fault without failed state");

    // A save request is only issued while the sequence is complete.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[18] |-> m_data_reg[3:0] == dseq_pkg::ST_COMPLETE)
        else $error("save request outside complete state");

    // Once separation is seen, only reset clears it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(sep_seen_reg))
        else $error("separation flag cleared");

    // The input side stalls only when both registers hold a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled while pipeline has room");

    // A stalled item in the input register does not advance the state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> $stable(state_reg) && $stable(entry_time_reg))
        else $error("state changed while result stalled");

endmodule

`default_nettype wire

[tb/sv/deployment_sequencer_unit_test.sv]
// Self-checking testbench for deployment_sequencer_unit: directed and random ticks and forced
// retries on the stream port, register settings over APB, status checked against a predictor
// or, for typed directed rows, the table. Depends on dseq_pkg and deployment_sequencer_unit.
module deployment_sequencer_unit_test;

    localparam int DIR_COUNT   = 25;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 108;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    // Field order follows m_tdata from the top bit down.
    typedef struct packed {
        logic             save;
        dseq_pkg::fault_t fault;
        logic [3:0]       sol_tries;
        logic             sol_done;
        logic [3:0]       ant_tries;
        logic             ant_done;
        logic             sep;
        logic             burn;
        dseq_pkg::state_t st;
    } status_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now;
        logic        sep;
        logic        sense;
        logic        elem;
        logic        typed;
        status_t     want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{dseq_pkg::CMD_TICK, 32'd0, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b1,
          '{1'b0, dseq_pkg::FAULT_NONE, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 1'b0,
            dseq_pkg::ST_INHIBITED}},
        '{dseq_pkg::CMD_TICK, 32'd100, 1'b1, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b1,
          '{1'b0, dseq_pkg::FAULT_NONE, 4'd0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0,
            dseq_pkg::ST_WAITING}},
        '{dseq_pkg::CMD_TICK, 32'd1800099, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1800100, 1'b0, 1'b0, dseq_pkg::ELEM_SOLAR, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1800100, 1'b1, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b1,
          '{1'b0, dseq_pkg::FAULT_NONE, 4'd0, 1'b0, 4'd1, 1'b0, 1'b1, 1'b1,
            dseq_pkg::ST_ANT_ACT}},
        '{dseq_pkg::CMD_TICK, 32'd1810099, 1'b0, 1'b1, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1810100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1815099, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1815100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1815100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1825100, 1'b1, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1830100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1830100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1840100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1845100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1845100, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b1,
          '{1'b0, dseq_pkg::FAULT_ANTENNA, 4'd0, 1'b0, 4'd3, 1'b0, 1'b1, 1'b0,
            dseq_pkg::ST_FAILED}},
        '{dseq_pkg::CMD_TICK, 32'd1845200, 1'b0, 1'b1, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_RETRY, 32'd1850000, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd1850000, 1'b0, 1'b1, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_RETRY, 32'hFFFF_FFF0, 1'b1, 1'b1, dseq_pkg::ELEM_SOLAR, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, dseq_pkg::ELEM_SOLAR, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd9998, 1'b0, 1'b0, dseq_pkg::ELEM_SOLAR, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd9999, 1'b0, 1'b0, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd14999, 1'b0, 1'b1, dseq_pkg::ELEM_ANTENNA, 1'b0, '0},
        '{dseq_pkg::CMD_TICK, 32'd15000, 1'b1, 1'b1, dseq_pkg::ELEM_SOLAR, 1'b1,
          '{1'b1, dseq_pkg::FAULT_NONE, 4'd1, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0,
            dseq_pkg::ST_COMPLETE}}
    };

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic [dseq_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dseq_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [dseq_pkg::ADDR_W-1:0]     paddr;
    logic [dseq_pkg::APB_DATA_W-1:0] pwdata;
    logic [dseq_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // Register shadows and sequencer state as the predictor sees them.
    logic [31:0]      cfg_wait, cfg_ant_burn, cfg_sol_burn, cfg_verify, cfg_retry;
    logic [3:0]       cfg_max_tries;
    logic             cfg_enable;
    dseq_pkg::state_t seq_state_q;
    logic [31:0]      entry_ms;
    logic [3:0]       ant_tries_q, sol_tries_q;
    logic             ant_done_q, sol_done_q, sep_seen_q, burn_q;

    status_t     pending_status[$];
    int          errors = 0;
    int          items_in = 0;
    int          items_out = 0;
    int          cfg_writes = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    deployment_sequencer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void enter(dseq_pkg::state_t st, logic [31:0] now);
        seq_state_q = st;
        entry_ms    = now;
    endfunction

    function automatic status_t predict_status(logic cmd, logic [31:0] now, logic sep,
                                               logic sense, logic elem);
        status_t     r;
        logic [31:0] elapsed;
        r       = '0;
        elapsed = now - entry_ms;
        if (cmd == dseq_pkg::CMD_RETRY) begin
            if (elem == dseq_pkg::ELEM_ANTENNA) begin
                ant_tries_q = '0;
                ant_done_q  = 1'b0;
                enter(dseq_pkg::ST_ANT_PEND, now);
            end else begin
                sol_tries_q = '0;
                sol_done_q  = 1'b0;
                enter(dseq_pkg::ST_SOL_PEND, now);
            end
        end else begin
            case (seq_state_q)
                dseq_pkg::ST_INHIBITED: if (sep) begin
                    sep_seen_q = 1'b1;
                    enter(dseq_pkg::ST_WAITING, now);
                end
                dseq_pkg::ST_WAITING: if (elapsed >= cfg_wait && cfg_enable) begin
                    enter(dseq_pkg::ST_ANT_PEND, now);
                end
                dseq_pkg::ST_ANT_PEND: if (sense) begin
                    ant_done_q = 1'b1;
                    enter(dseq_pkg::ST_SOL_PEND, now);
                end else if (ant_tries_q < cfg_max_tries) begin
                    burn_q      = 1'b1;
                    ant_tries_q = ant_tries_q + 4'd1;
                    enter(dseq_pkg::ST_ANT_ACT, now);
                end else begin
                    enter(dseq_pkg::ST_FAILED, now);
                    r.fault = dseq_pkg::FAULT_ANTENNA;
                end
                dseq_pkg::ST_ANT_ACT: if (elapsed >= cfg_ant_burn) begin
                    burn_q = 1'b0;
                    enter(dseq_pkg::ST_ANT_VER, now);
                end
                dseq_pkg::ST_ANT_VER: if (sense) begin
                    ant_done_q = 1'b1;
                    enter(dseq_pkg::ST_SOL_PEND, now);
                end else if (elapsed >= cfg_verify && elapsed >= cfg_retry) begin
                    enter(dseq_pkg::ST_ANT_PEND, now);
                end
                dseq_pkg::ST_SOL_PEND: if (sense) begin
                    sol_done_q = 1'b1;
                    enter(dseq_pkg::ST_COMPLETE, now);
                end else if (sol_tries_q < cfg_max_tries) begin
                    burn_q      = 1'b1;
                    sol_tries_q = sol_tries_q + 4'd1;
                    enter(dseq_pkg::ST_SOL_ACT, now);
                end else begin
                    enter(dseq_pkg::ST_FAILED, now);
                    r.fault = dseq_pkg::FAULT_SOLAR;
                end
                dseq_pkg::ST_SOL_ACT: if (elapsed >= cfg_sol_burn) begin
                    burn_q = 1'b0;
                    enter(dseq_pkg::ST_SOL_VER, now);
                end
                dseq_pkg::ST_SOL_VER: if (sense) begin
                    sol_done_q = 1'b1;
                    enter(dseq_pkg::ST_COMPLETE, now);
                end else if (elapsed >= cfg_verify && elapsed >= cfg_retry) begin
                    enter(dseq_pkg::ST_SOL_PEND, now);
                end
                dseq_pkg::ST_COMPLETE: r.save = 1'b1;
                dseq_pkg::ST_FAILED: ;
                default: begin
                    enter(dseq_pkg::ST_INHIBITED, now);
                    r.fault = dseq_pkg::FAULT_INVALID;
                end
            endcase
        end
        r.st        = seq_state_q;
        r.burn      = burn_q;
        r.sep       = sep_seen_q;
        r.ant_done  = ant_done_q;
        r.ant_tries = ant_tries_q;
        r.sol_done  = sol_done_q;
        r.sol_tries = sol_tries_q;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the access phase.
    task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_writes++;
        case (idx)
            dseq_pkg::REG_WAIT_TIME:     cfg_wait      = value;
            dseq_pkg::REG_ANTENNA_BURN:  cfg_ant_burn  = value;
            dseq_pkg::REG_SOLAR_BURN:    cfg_sol_burn  = value;
            dseq_pkg::REG_VERIFY_TIME:   cfg_verify    = value;
            dseq_pkg::REG_RETRY_DELAY:   cfg_retry     = value;
            dseq_pkg::REG_MAX_ATTEMPTS:  cfg_max_tries = value[3:0];
            dseq_pkg::REG_DEPLOY_ENABLE: cfg_enable    = value[0];
            default: ;
        endcase
    endtask

    task automatic set_timing(logic [31:0] wait_ms, logic [31:0] ant_ms, logic [31:0] sol_ms,
                              logic [31:0] verify_ms, logic [31:0] retry_ms,
                              logic [3:0] max_tries, logic enable);
        cfg_write(dseq_pkg::REG_WAIT_TIME, wait_ms);
        cfg_write(dseq_pkg::REG_ANTENNA_BURN, ant_ms);
        cfg_write(dseq_pkg::REG_SOLAR_BURN, sol_ms);
        cfg_write(dseq_pkg::REG_VERIFY_TIME, verify_ms);
        cfg_write(dseq_pkg::REG_RETRY_DELAY, retry_ms);
        cfg_write(dseq_pkg::REG_MAX_ATTEMPTS, {28'd0, max_tries});
        cfg_write(dseq_pkg::REG_DEPLOY_ENABLE, {31'd0, enable});
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(logic cmd, logic [31:0] now, logic sep, logic sense, logic elem,
                             logic typed, status_t want);
        status_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {5'd0, elem, sense, sep, now};
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_status(cmd, now, sep, sense, elem);
        pending_status.push_back(typed ? want : predicted);
        items_in++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        status_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_t'(m_tdata[18:0]);
            items_out++;
            if (pending_status.size() == 0) begin
                $display("%0t: unexpected status transaction, expected none, got %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = pending_status.pop_front();
                check_field("seq_state", want.st, got.st);
                check_field("burn_enable", 4'(want.burn), 4'(got.burn));
                check_field("separated", 4'(want.sep), 4'(got.sep));
                check_field("ant_confirmed", 4'(want.ant_done), 4'(got.ant_done));
                check_field("antenna_tries", want.ant_tries, got.ant_tries);
                check_field("sol_confirmed", 4'(want.sol_done), 4'(got.sol_done));
                check_field("solar_tries", want.sol_tries, got.sol_tries);
                check_field("fault_event", 4'(want.fault), 4'(got.fault));
                check_field("save_request", 4'(want.save), 4'(got.save));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("deployment_sequencer_unit: mismatch");
            $finish;
        end
    end

    initial begin
        logic [31:0] tnow;
        logic        full_jumps;
        int          scale;
        logic        cmd, sep, sense, elem;

        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        cfg_wait      = dseq_pkg::RST_WAIT_TIME;
        cfg_ant_burn  = dseq_pkg::RST_ANTENNA_BURN;
        cfg_sol_burn  = dseq_pkg::RST_SOLAR_BURN;
        cfg_verify    = dseq_pkg::RST_VERIFY_TIME;
        cfg_retry     = dseq_pkg::RST_RETRY_DELAY;
        cfg_max_tries = dseq_pkg::RST_MAX_ATTEMPTS;
        cfg_enable    = 1'b1;
        seq_state_q   = dseq_pkg::ST_INHIBITED;
        entry_ms      = '0;
        ant_tries_q   = '0;
        sol_tries_q   = '0;
        ant_done_q    = 1'b0;
        sol_done_q    = 1'b0;
        sep_seen_q    = 1'b0;
        burn_q        = 1'b0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIR_COUNT; i++) begin
            send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].now, DIR_ROWS[i].sep, DIR_ROWS[i].sense,
                      DIR_ROWS[i].elem, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end
        drain();

        tnow = 32'd15000;
        for (int p = 1; p <= PHASES; p++) begin
            full_jumps = 1'b0;
            case (p)
                1: begin
                    set_timing(32'd20, 32'd12, 32'd7, 32'd6, 32'd9, 4'd3, 1'b1);
                    cfg_write(REG_UNMAPPED, $urandom);
                    scale = 15;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                2: begin
                    set_timing(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd0, 1'b1);
                    scale = 5;
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                3: begin
                    set_timing('1, '1, '1, '1, '1, 4'd15, 1'b0);
                    full_jumps = 1'b1;
                    scale = 0;
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                4: begin
                    set_timing($urandom_range(0, 30), $urandom_range(0, 30),
                               $urandom_range(0, 30), $urandom_range(0, 30),
                               $urandom_range(0, 30), 4'd15, 1'b1);
                    scale = 20;
                    send_idle_pct = 7;
                    recv_stall_pct = 7;
                end
                default: begin
                    set_timing($urandom_range(0, 40), $urandom_range(0, 40),
                               $urandom_range(0, 40), $urandom_range(0, 40),
                               $urandom_range(0, 40), 4'($urandom_range(1, 15)),
                               $urandom_range(0, 3) != 0);
                    scale = 25;
                    send_idle_pct = (p == 5) ? 63 : (p == 7) ? 7 : 0;
                    recv_stall_pct = (p == 6) ? 63 : (p == 7) ? 7 : 0;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (full_jumps || $urandom_range(0, 24) == 0) begin
                    tnow = $urandom;
                end else begin
                    tnow = tnow + $urandom_range(0, scale);
                end
                cmd   = ($urandom_range(0, 99) < 8) ? dseq_pkg::CMD_RETRY : dseq_pkg::CMD_TICK;
                sep   = $urandom_range(0, 99) < 80;
                sense = $urandom_range(0, 99) < 25;
                elem  = 1'($urandom_range(0, 1));
                send_item(cmd, tnow, sep, sense, elem, 1'b0, '0);
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge aclk);
        $display("Sent %0d ticks and retry commands, checked %0d status transactions,",
                 items_in, items_out);
        $display("with %0d register writes over %0d settings and four idle patterns.",
                 cfg_writes, PHASES + 1);
        if (errors == 0 && pending_status.size() == 0) begin
            $display("deployment_sequencer_unit: match");
        end else begin
            $display("deployment_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dseq_pkg.sv
rtl/deployment_sequencer_unit.sv
tb/sv/deployment_sequencer_unit_test.sv
